// ----- rtl/core/mttp_pkg.sv -----
// shared types, constants and helpers of the marker tilt and tip pose block
package mttp_pkg;

   typedef enum logic [4:0] {
      S_IDLE, S_SQ_X, S_SQ_Y, S_SQRT, S_GAIN, S_SMOOTH, S_RINIT, S_RED, S_R2,
      S_TS_MUL, S_TS_DIV, S_TC_MUL, S_TC_DIV, S_QUAD, S_TIP1, S_TIP2, S_TIP3,
      S_TIP4, S_FINISH
   } state_type;

   localparam int MulAW  = 64;
   localparam int MulBW  = 32;
   localparam int DivNW  = 34;
   localparam int DivDW  = 8;
   localparam int SqrtRW = 48;
   localparam int SqrtQW = 24;

   localparam logic [2:0] CsrXMin    = 3'd0;
   localparam logic [2:0] CsrYMin    = 3'd1;
   localparam logic [2:0] CsrBase    = 3'd2;
   localparam logic [2:0] CsrGain    = 3'd3;
   localparam logic [2:0] CsrHOffset = 3'd4;
   localparam logic [2:0] CsrTipDist = 3'd5;
   localparam logic [2:0] CsrAxisX   = 3'd6;
   localparam logic [2:0] CsrAxisY   = 3'd7;

   localparam logic signed [36:0] HalfPi     = 37'sd1686629713;
   localparam logic signed [31:0] OneQ30     = 32'sd1073741824;
   localparam logic [2:0]         TaylorLast = 3'd6;

   typedef struct packed {
      logic                    start;
      logic signed [MulAW-1:0] a;
      logic signed [MulBW-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [MulAW-1:0] p;
   } mul_rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [DivNW-1:0] num;
      logic [DivDW-1:0]        den;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DivNW-1:0] q;
      logic                    rem_nz;
   } div_rsp_type;

   typedef struct packed {
      logic              start;
      logic [SqrtRW-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [SqrtQW-1:0] root;
   } sqrt_rsp_type;

   function automatic logic signed [23:0] sat_s24(input logic signed [39:0] v);
      if (v > 40'sd8388607) begin
         return 24'sh7fffff;
      end else if (v < -40'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   function automatic logic signed [31:0] sat_s32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // divisors of the taylor terms, (2n)(2n+1) for sine and (2n-1)(2n) for cosine
   function automatic logic [DivDW-1:0] sin_den(input logic [2:0] n);
      unique case (n)
         3'd1:    return 8'd6;
         3'd2:    return 8'd20;
         3'd3:    return 8'd42;
         3'd4:    return 8'd72;
         3'd5:    return 8'd110;
         3'd6:    return 8'd156;
         default: return 8'd1;
      endcase
   endfunction

   function automatic logic [DivDW-1:0] cos_den(input logic [2:0] n);
      unique case (n)
         3'd1:    return 8'd2;
         3'd2:    return 8'd12;
         3'd3:    return 8'd30;
         3'd4:    return 8'd56;
         3'd5:    return 8'd90;
         3'd6:    return 8'd132;
         default: return 8'd1;
      endcase
   endfunction

endpackage

// ----- rtl/core/mttp_mul.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
module mttp_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  mttp_pkg::mul_req_type mul_req,
   output mttp_pkg::mul_rsp_type mul_rsp
);
   import mttp_pkg::*;

   localparam int CntW = $clog2(MulBW);

   logic             busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [MulAW-1:0] ma_ff, ma_in, acc_ff, acc_in;
   logic [MulBW-1:0] mb_ff, mb_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      if (!busy_ff) begin
         if (mul_req.start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            acc_in  = '0;
            neg_in  = mul_req.a[MulAW-1] ^ mul_req.b[MulBW-1];
            ma_in   = mul_req.a[MulAW-1] ? MulAW'(-mul_req.a) : MulAW'(mul_req.a);
            mb_in   = mul_req.b[MulBW-1] ? MulBW'(-mul_req.b) : MulBW'(mul_req.b);
         end
      end else begin
         if (mb_ff[0]) begin
            acc_in = acc_ff + ma_ff;
         end
         ma_in  = ma_ff << 1;
         mb_in  = mb_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(MulBW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.p    = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);

endmodule

// ----- rtl/core/mttp_div.sv -----
// bit-serial restoring divider, signed numerator by small unsigned divisor, truncating
module mttp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mttp_pkg::div_req_type div_req,
   output mttp_pkg::div_rsp_type div_rsp
);
   import mttp_pkg::*;

   localparam int CntW = $clog2(DivNW);

   logic             busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [DivNW-1:0] mag_ff, mag_in, q_ff, q_in;
   logic [DivDW-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [DivDW:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, mag_ff[DivNW-1]};
      if (!busy_ff) begin
         if (div_req.start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = '0;
            q_in    = '0;
            den_in  = div_req.den;
            neg_in  = div_req.num[DivNW-1];
            mag_in  = div_req.num[DivNW-1] ? DivNW'(-div_req.num) : DivNW'(div_req.num);
         end
      end else begin
         mag_in = mag_ff << 1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DivDW'(rem_sh - {1'b0, den_ff});
            q_in   = {q_ff[DivNW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DivDW-1:0];
            q_in   = {q_ff[DivNW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(DivNW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.q      = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   assign div_rsp.rem_nz = (rem_ff != '0);

endmodule

// ----- rtl/core/mttp_sqrt.sv -----
// integer square root, one result bit per cycle
module mttp_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  mttp_pkg::sqrt_req_type sqrt_req,
   output mttp_pkg::sqrt_rsp_type sqrt_rsp
);
   import mttp_pkg::*;

   localparam int CntW = $clog2(SqrtQW);

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [SqrtRW-1:0] a_ff, a_in, res_ff, res_in, bit_ff, bit_in, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (!busy_ff) begin
         if (sqrt_req.start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            a_in    = sqrt_req.radicand;
            res_in  = '0;
            bit_in  = SqrtRW'(1) << (SqrtRW - 2);
         end
      end else begin
         if (a_ff >= trial) begin
            a_in   = a_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(SqrtQW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = res_ff[SqrtQW-1:0];

endmodule

// ----- rtl/core/marker_tilt_and_tip_pose.sv -----
// top level: marker tilt angle, lift height and rotated tool tip per frame
// per frame with a marker: 20 products, 12 quotients and one more once smoothing runs, a root
//   and the quarter-turn steps; without a marker only the finish step runs
// throughput: one transaction at a time, the next is taken the cycle after the result is registered
// reset: synchronous active-high, clears configuration and control registers, smoothing state and held pose
module marker_tilt_and_tip_pose (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_marker_present,
   input  logic [15:0] req_corner_x0,
   input  logic [15:0] req_corner_y0,
   input  logic [15:0] req_corner_x1,
   input  logic [15:0] req_corner_y1,
   input  logic [15:0] req_corner_x2,
   input  logic [15:0] req_corner_y2,
   input  logic [15:0] req_corner_x3,
   input  logic [15:0] req_corner_y3,
   input  logic signed [31:0] req_measured_height,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pose_valid,
   output logic signed [23:0] rsp_tilt_angle,
   output logic signed [31:0] rsp_lift_height,
   output logic signed [31:0] rsp_tip_x,
   output logic signed [31:0] rsp_tip_y
);
   import mttp_pkg::*;

   // configuration registers
   logic [15:0]        cfg_xmin_ff, cfg_ymin_ff;
   logic signed [23:0] cfg_base_ff;
   logic signed [31:0] cfg_gain_ff, cfg_hoff_ff, cfg_tipd_ff, cfg_ax_ff, cfg_ay_ff;

   // sequencer
   state_type state_ff, state_in;
   logic      issued_ff, issued_in;

   // per-transaction working registers
   logic               present_ff, present_in;
   logic signed [31:0] h_ff, h_in;
   logic signed [18:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [23:0]        d_ff, d_in;
   logic signed [33:0] num_ff, num_in;
   logic signed [35:0] r_ff, r_in;
   logic signed [3:0]  k_ff, k_in;
   logic signed [31:0] r2_ff, r2_in, st_ff, st_in, ct_ff, ct_in, s_ff, s_in, c_ff, c_in;
   logic signed [31:0] sn_ff, sn_in, cs_ff, cs_in;
   logic signed [33:0] px_ff, px_in, py_ff, py_in;
   logic [2:0]         n_ff, n_in;

   // state carried between frames
   logic               started_ff, started_in;
   logic signed [23:0] ang_ff, ang_in;
   logic signed [31:0] held_h_ff, held_h_in, held_tx_ff, held_tx_in, held_ty_ff, held_ty_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in, rsp_pv_ff, rsp_pv_in;
   logic signed [23:0] rsp_ang_ff, rsp_ang_in;
   logic signed [31:0] rsp_h_ff, rsp_h_in, rsp_tx_ff, rsp_tx_in, rsp_ty_ff, rsp_ty_in;

   mul_req_type  mul_req;
   mul_rsp_type  mul_rsp;
   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   // shared arithmetic around the unit results
   logic [17:0]        sum_x, sum_y;
   logic signed [63:0] gain_rnd, taylor_rnd, tip_sum, tip_rnd;
   logic signed [39:0] gain_diff;
   logic signed [23:0] new_ang;
   logic signed [33:0] smooth_q;
   logic signed [36:0] two_r;
   logic signed [32:0] quad_s, quad_c;
   logic signed [31:0] tip_axis, tip_res;
   logic               accept, rsp_free;

   mttp_mul  u_mul  (.clock(clock), .reset(reset), .mul_req(mul_req), .mul_rsp(mul_rsp));
   mttp_div  u_div  (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));
   mttp_sqrt u_sqrt (.clock(clock), .reset(reset), .sqrt_req(sqrt_req), .sqrt_rsp(sqrt_rsp));

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // corner sums, centre offset in 1/64 px
   assign sum_x = 18'(req_corner_x0) + 18'(req_corner_x1) + 18'(req_corner_x2)
                + 18'(req_corner_x3);
   assign sum_y = 18'(req_corner_y0) + 18'(req_corner_y1) + 18'(req_corner_y2)
                + 18'(req_corner_y3);

   // angle from distance: base minus rounded gain product, saturated
   assign gain_rnd  = (mul_rsp.p + 64'sd131072) >>> 18;
   assign gain_diff = 40'(cfg_base_ff) - gain_rnd[39:0];
   assign new_ang   = sat_s24(gain_diff);

   // floor from truncated quotient
   assign smooth_q = div_rsp.q - 34'(num_ff[33] && div_rsp.rem_nz);

   // rounded taylor product, used for r squared and, negated, for the divider
   assign taylor_rnd = (mul_rsp.p + 64'sd536870912) >>> 30;

   assign two_r = {r_ff, 1'b0};

   // quadrant select of the reduced sine and cosine
   always_comb begin
      unique case (k_ff[1:0])
         2'd0: begin quad_s = 33'(s_ff);  quad_c = 33'(c_ff);  end
         2'd1: begin quad_s = 33'(c_ff);  quad_c = -33'(s_ff); end
         2'd2: begin quad_s = -33'(s_ff); quad_c = -33'(c_ff); end
         2'd3: begin quad_s = -33'(c_ff); quad_c = 33'(s_ff);  end
      endcase
   end

   // tip rotation: sum or difference of two products, rounded to q16.16 and moved back to the axis
   assign tip_sum  = (state_ff == S_TIP2) ? acc_ff + mul_rsp.p : acc_ff - mul_rsp.p;
   assign tip_rnd  = (tip_sum + 64'sd134217728) >>> 28;
   assign tip_axis = (state_ff == S_TIP2) ? cfg_ax_ff : cfg_ay_ff;
   assign tip_res  = sat_s32(tip_rnd[39:0] + 40'(tip_axis));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = req_marker_present ? S_SQ_X : S_FINISH;
         S_SQ_X:   if (mul_rsp.done) state_in = S_SQ_Y;
         S_SQ_Y:   if (mul_rsp.done) state_in = S_SQRT;
         S_SQRT:   if (sqrt_rsp.done) state_in = S_GAIN;
         S_GAIN:   if (mul_rsp.done) state_in = started_ff ? S_SMOOTH : S_RINIT;
         S_SMOOTH: if (div_rsp.done) state_in = S_RINIT;
         S_RINIT:  state_in = S_RED;
         S_RED: begin
            if (two_r < HalfPi && two_r >= -HalfPi) state_in = S_R2;
         end
         S_R2:     if (mul_rsp.done) state_in = S_TS_MUL;
         S_TS_MUL: if (mul_rsp.done) state_in = S_TS_DIV;
         S_TS_DIV: if (div_rsp.done) state_in = S_TC_MUL;
         S_TC_MUL: if (mul_rsp.done) state_in = S_TC_DIV;
         S_TC_DIV: begin
            if (div_rsp.done) state_in = (n_ff == TaylorLast) ? S_QUAD : S_TS_MUL;
         end
         S_QUAD:   state_in = S_TIP1;
         S_TIP1:   if (mul_rsp.done) state_in = S_TIP2;
         S_TIP2:   if (mul_rsp.done) state_in = S_TIP3;
         S_TIP3:   if (mul_rsp.done) state_in = S_TIP4;
         S_TIP4:   if (mul_rsp.done) state_in = S_FINISH;
         S_FINISH: if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and unit requests
   always_comb begin
      issued_in  = issued_ff;
      present_in = present_ff;
      h_in       = h_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      acc_in     = acc_ff;
      d_in       = d_ff;
      num_in     = num_ff;
      r_in       = r_ff;
      k_in       = k_ff;
      r2_in      = r2_ff;
      st_in      = st_ff;
      ct_in      = ct_ff;
      s_in       = s_ff;
      c_in       = c_ff;
      sn_in      = sn_ff;
      cs_in      = cs_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      n_in       = n_ff;
      started_in = started_ff;
      ang_in     = ang_ff;
      held_h_in  = held_h_ff;
      held_tx_in = held_tx_ff;
      held_ty_in = held_ty_ff;
      rsp_pv_in  = rsp_pv_ff;
      rsp_ang_in = rsp_ang_ff;
      rsp_h_in   = rsp_h_ff;
      rsp_tx_in  = rsp_tx_ff;
      rsp_ty_in  = rsp_ty_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      mul_req  = '0;
      div_req  = '0;
      sqrt_req = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               present_in = req_marker_present;
               h_in  = sat_s32(40'(req_measured_height) + 40'(cfg_hoff_ff));
               dx_in = $signed({1'b0, sum_x}) - $signed({1'b0, cfg_xmin_ff, 2'b00});
               dy_in = $signed({1'b0, sum_y}) - $signed({1'b0, cfg_ymin_ff, 2'b00});
            end
         end
         S_SQ_X: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(dx_ff);
            mul_req.b     = 32'(dx_ff);
            if (mul_rsp.done) acc_in = mul_rsp.p;
         end
         S_SQ_Y: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(dy_ff);
            mul_req.b     = 32'(dy_ff);
            if (mul_rsp.done) acc_in = acc_ff + mul_rsp.p;
         end
         S_SQRT: begin
            sqrt_req.start    = !issued_ff;
            sqrt_req.radicand = {acc_ff[39:0], 8'b0};
            if (sqrt_rsp.done) d_in = sqrt_rsp.root;
         end
         S_GAIN: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(cfg_gain_ff);
            mul_req.b     = $signed({8'b0, d_ff});
            if (mul_rsp.done) begin
               if (!started_ff) begin
                  // first angle after reset goes straight through
                  ang_in     = new_ang;
                  started_in = 1'b1;
               end else begin
                  num_in = (34'(new_ang) <<< 2) + 34'(ang_ff) + 34'sd2;
               end
            end
         end
         S_SMOOTH: begin
            div_req.start = !issued_ff;
            div_req.num   = num_ff;
            div_req.den   = 8'd5;
            if (div_rsp.done) ang_in = smooth_q[23:0];
         end
         S_RINIT: begin
            r_in = 36'(ang_ff) <<< 10;
            k_in = '0;
         end
         S_RED: begin
            // quarter-turn reduction, one step a cycle
            if (two_r >= HalfPi) begin
               r_in = r_ff - 36'(HalfPi);
               k_in = k_ff + 4'sd1;
            end else if (two_r < -HalfPi) begin
               r_in = r_ff + 36'(HalfPi);
               k_in = k_ff - 4'sd1;
            end else begin
               st_in = r_ff[31:0];
               s_in  = r_ff[31:0];
               ct_in = OneQ30;
               c_in  = OneQ30;
               n_in  = 3'd1;
            end
         end
         S_R2: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(r_ff);
            mul_req.b     = r_ff[31:0];
            if (mul_rsp.done) r2_in = taylor_rnd[31:0];
         end
         S_TS_MUL: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(st_ff);
            mul_req.b     = r2_ff;
            if (mul_rsp.done) num_in = -taylor_rnd[33:0];
         end
         S_TS_DIV: begin
            div_req.start = !issued_ff;
            div_req.num   = num_ff;
            div_req.den   = sin_den(n_ff);
            if (div_rsp.done) begin
               st_in = div_rsp.q[31:0];
               s_in  = s_ff + div_rsp.q[31:0];
            end
         end
         S_TC_MUL: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(ct_ff);
            mul_req.b     = r2_ff;
            if (mul_rsp.done) num_in = -taylor_rnd[33:0];
         end
         S_TC_DIV: begin
            div_req.start = !issued_ff;
            div_req.num   = num_ff;
            div_req.den   = cos_den(n_ff);
            if (div_rsp.done) begin
               ct_in = div_rsp.q[31:0];
               c_in  = c_ff + div_rsp.q[31:0];
               n_in  = n_ff + 3'd1;
            end
         end
         S_QUAD: begin
            // q.30 to q.28 with rounding, tip relative to the axis
            sn_in     = 32'((quad_s + 33'sd2) >>> 2);
            cs_in     = 32'((quad_c + 33'sd2) >>> 2);
            px_in     = 34'(cfg_tipd_ff) - 34'(cfg_ax_ff);
            py_in     = 34'(h_ff) - 34'(cfg_ay_ff);
            held_h_in = h_ff;
         end
         S_TIP1: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(px_ff);
            mul_req.b     = cs_ff;
            if (mul_rsp.done) acc_in = mul_rsp.p;
         end
         S_TIP2: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(py_ff);
            mul_req.b     = sn_ff;
            if (mul_rsp.done) held_tx_in = tip_res;
         end
         S_TIP3: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(py_ff);
            mul_req.b     = cs_ff;
            if (mul_rsp.done) acc_in = mul_rsp.p;
         end
         S_TIP4: begin
            mul_req.start = !issued_ff;
            mul_req.a     = 64'(px_ff);
            mul_req.b     = sn_ff;
            if (mul_rsp.done) held_ty_in = tip_res;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pv_in    = present_ff;
               rsp_ang_in   = ang_ff;
               rsp_h_in     = held_h_ff;
               rsp_tx_in    = held_tx_ff;
               rsp_ty_in    = held_ty_ff;
            end
         end
         default: ;
      endcase

      // one request per unit operation, cleared when its result comes back
      if (mul_req.start || div_req.start || sqrt_req.start) begin
         issued_in = 1'b1;
      end
      if (mul_rsp.done || div_rsp.done || sqrt_rsp.done) begin
         issued_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_xmin_ff <= '0;
         cfg_ymin_ff <= '0;
         cfg_base_ff <= '0;
         cfg_gain_ff <= '0;
         cfg_hoff_ff <= '0;
         cfg_tipd_ff <= '0;
         cfg_ax_ff   <= '0;
         cfg_ay_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrXMin:    cfg_xmin_ff <= csr_wdata[15:0];
            CsrYMin:    cfg_ymin_ff <= csr_wdata[15:0];
            CsrBase:    cfg_base_ff <= csr_wdata[23:0];
            CsrGain:    cfg_gain_ff <= csr_wdata;
            CsrHOffset: cfg_hoff_ff <= csr_wdata;
            CsrTipDist: cfg_tipd_ff <= csr_wdata;
            CsrAxisX:   cfg_ax_ff   <= csr_wdata;
            CsrAxisY:   cfg_ay_ff   <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         started_ff   <= 1'b0;
         ang_ff       <= '0;
         held_h_ff    <= '0;
         held_tx_ff   <= '0;
         held_ty_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         started_ff   <= started_in;
         ang_ff       <= ang_in;
         held_h_ff    <= held_h_in;
         held_tx_ff   <= held_tx_in;
         held_ty_ff   <= held_ty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      present_ff <= present_in;
      h_ff       <= h_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      acc_ff     <= acc_in;
      d_ff       <= d_in;
      num_ff     <= num_in;
      r_ff       <= r_in;
      k_ff       <= k_in;
      r2_ff      <= r2_in;
      st_ff      <= st_in;
      ct_ff      <= ct_in;
      s_ff       <= s_in;
      c_ff       <= c_in;
      sn_ff      <= sn_in;
      cs_ff      <= cs_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      n_ff       <= n_in;
      rsp_pv_ff  <= rsp_pv_in;
      rsp_ang_ff <= rsp_ang_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_tx_ff  <= rsp_tx_in;
      rsp_ty_ff  <= rsp_ty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pose_valid  = rsp_pv_ff;
   assign rsp_tilt_angle  = rsp_ang_ff;
   assign rsp_lift_height = rsp_h_ff;
   assign rsp_tip_x       = rsp_tx_ff;
   assign rsp_tip_y       = rsp_ty_ff;

   // multiplier results only come back while the sequencer waits on a product
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_SQ_X || state_ff == S_SQ_Y || state_ff == S_GAIN ||
                        state_ff == S_R2 || state_ff == S_TS_MUL || state_ff == S_TC_MUL ||
                        state_ff == S_TIP1 || state_ff == S_TIP2 || state_ff == S_TIP3 ||
                        state_ff == S_TIP4))
      else $error("multiplier result outside a product step");

   // divider results only while a quotient is awaited
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_SMOOTH || state_ff == S_TS_DIV || state_ff == S_TC_DIV))
      else $error("divider result outside a quotient step");

   // root result only in the square root step
   a_sqrt_done_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_rsp.done |-> state_ff == S_SQRT)
      else $error("square root result outside its step");

   // smoothing starts only from the first angle computation
   a_started_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(started_ff) |-> $past(state_ff == S_GAIN && mul_rsp.done))
      else $error("smoothing started without an angle");

endmodule
